FILE: rtl/mpq_pkg.sv
// Package with the command, status and state codes and the stored entry type of the queue.
`timescale 1ns / 1ps

package mpq_pkg;

  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_REMOVE   = 2'd1;
  localparam logic [1:0] MODE_PEEK     = 2'd2;
  localparam logic [1:0] MODE_PEEK_ALT = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FREE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] record;
    logic [7:0]  age;
    logic [15:0] stamp;
  } entry_t;

endpackage

FILE: rtl/max_priority_queue_unit.sv
// Bounded max-priority queue held in an unsorted slot memory with a registered read port.
`timescale 1ns / 1ps

// A command word is taken when start is high and busy is low. Mode selects insert,
// remove-highest or peek-highest; prio_level, record_id and holder_age carry the entry
// to insert. Every command gives exactly one result word, shown on the result ports for
// one cycle while done is high; the receiver must take it then, as it cannot stall.
// A refused command (insert when full, remove or peek when empty) reports in the cycle
// after it was taken. An insert walks the valid bits one slot a cycle to the lowest free
// slot and writes the entry there. Remove and peek read every slot of the memory once
// through a single comparator, one slot a cycle, before they report; that scan sets the
// rate of the block.
// Among equal priorities the entry inserted earliest wins, then the lower slot.
// Reset clears the valid bits, the entry count and the insertion stamp at once; the
// slot memory itself is not cleared and needs no clearing pass. One command is worked
// on at a time; busy stays high until the result word of an accepted command is shown.
module max_priority_queue_unit
  import mpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  prio_level,
  input  logic [15:0] record_id,
  input  logic [7:0]  holder_age,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  out_prio,
  output logic [15:0] out_record,
  output logic [7:0]  out_age,
  output logic [4:0]  entry_count,
  output logic        is_empty
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  state_t          state;
  logic [CAPACITY-1:0] valid;
  logic [CW-1:0]   count;
  logic [15:0]     next_stamp;
  logic [IW-1:0]   scan_idx;
  logic            is_remove;
  logic [7:0]      ins_prio;
  logic [15:0]     ins_record;
  logic [7:0]      ins_age;

  entry_t          mem [CAPACITY];
  entry_t          rd_data;
  logic            rd_pend;
  logic [IW-1:0]   rd_idx;

  logic            have_best;
  logic [7:0]      best_prio;
  logic [15:0]     best_old;
  logic [IW-1:0]   best_idx;
  logic [15:0]     best_record;
  logic [7:0]      best_age;

  logic [15:0]     cand_old;
  logic            take;
  logic [7:0]      best_prio_next;
  logic [15:0]     best_old_next;
  logic [IW-1:0]   best_idx_next;
  logic [15:0]     best_record_next;
  logic [7:0]      best_age_next;

  assign busy = (state != S_IDLE);

  assign cand_old = next_stamp - rd_data.stamp;

  always_comb begin
    take = rd_pend && valid[rd_idx] &&
           (!have_best || (rd_data.prio > best_prio) ||
            ((rd_data.prio == best_prio) && (cand_old > best_old)));
    if (take) begin
      best_prio_next   = rd_data.prio;
      best_old_next    = cand_old;
      best_idx_next    = rd_idx;
      best_record_next = rd_data.record;
      best_age_next    = rd_data.age;
    end else begin
      best_prio_next   = best_prio;
      best_old_next    = best_old;
      best_idx_next    = best_idx;
      best_record_next = best_record;
      best_age_next    = best_age;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      rd_data <= mem[scan_idx];
    end
    if ((state == S_FREE) && !valid[scan_idx]) begin
      mem[scan_idx] <= '{prio: ins_prio, record: ins_record, age: ins_age,
                         stamp: next_stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      count      <= '0;
      next_stamp <= '0;
      done       <= 1'b0;
      rd_pend    <= 1'b0;
      have_best  <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      if (rd_pend) begin
        have_best   <= have_best || take;
        best_prio   <= best_prio_next;
        best_old    <= best_old_next;
        best_idx    <= best_idx_next;
        best_record <= best_record_next;
        best_age    <= best_age_next;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            scan_idx   <= '0;
            have_best  <= 1'b0;
            ins_prio   <= prio_level;
            ins_record <= record_id;
            ins_age    <= holder_age;
            case (mode)
              MODE_INSERT: begin
                is_remove <= 1'b0;
                if (count == FULL_COUNT) begin
                  done        <= 1'b1;
                  status      <= STATUS_FULL;
                  out_prio    <= '0;
                  out_record  <= '0;
                  out_age     <= '0;
                  entry_count <= 5'(count);
                  is_empty    <= (count == '0);
                end else begin
                  state <= S_FREE;
                end
              end
              default: begin
                is_remove <= (mode == MODE_REMOVE);
                if (count == '0) begin
                  done        <= 1'b1;
                  status      <= STATUS_EMPTY;
                  out_prio    <= '0;
                  out_record  <= '0;
                  out_age     <= '0;
                  entry_count <= 5'(count);
                  is_empty    <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_FREE: begin
          if (!valid[scan_idx]) begin
            valid[scan_idx] <= 1'b1;
            count           <= count + 1'b1;
            next_stamp      <= next_stamp + 16'd1;
            done            <= 1'b1;
            status          <= STATUS_OK;
            out_prio        <= ins_prio;
            out_record      <= ins_record;
            out_age         <= ins_age;
            entry_count     <= 5'(count + 1'b1);
            is_empty        <= 1'b0;
            state           <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_SCAN: begin
          rd_pend <= 1'b1;
          rd_idx  <= scan_idx;
          if (scan_idx == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          done       <= 1'b1;
          status     <= STATUS_OK;
          out_prio   <= best_prio_next;
          out_record <= best_record_next;
          out_age    <= best_age_next;
          if (is_remove) begin
            valid[best_idx_next] <= 1'b0;
            count                <= count - 1'b1;
            entry_count          <= 5'(count - 1'b1);
            is_empty             <= (count == CW'(1));
          end else begin
            entry_count <= 5'(count);
            is_empty    <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("Result word shown while a command is still in progress.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("Entry count exceeds the capacity.");

  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == count)
    else $error("Entry count disagrees with the valid bits.");

  a_busy_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("Command finished without a result word.");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_INSERT) && (count == FULL_COUNT))
      |=> (done && (status == STATUS_FULL)))
    else $error("Insert into a full queue was not refused at once.");

endmodule

FILE: sim/tb_max_priority_queue_unit.sv
// Self-checking testbench for the bounded max-priority queue unit.
`timescale 1ns / 1ps

module tb_max_priority_queue_unit
  import mpq_pkg::*;
();

  localparam int DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 20;
  localparam int CHURN_PAIRS = 24;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [15:0] record;
    logic [7:0]  age;
    logic [4:0]  count;
    logic        empty;
  } reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = MODE_INSERT;
  logic [7:0]  prio_level = '0;
  logic [15:0] record_id = '0;
  logic [7:0]  holder_age = '0;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  out_prio;
  logic [15:0] out_record;
  logic [7:0]  out_age;
  logic [4:0]  entry_count;
  logic        is_empty;

  logic [7:0]  shadow_prio [DEPTH];
  logic [15:0] shadow_record [DEPTH];
  logic [7:0]  shadow_age [DEPTH];
  logic [15:0] shadow_stamp [DEPTH];
  logic        shadow_valid [DEPTH];
  int          shadow_count = 0;
  logic [15:0] shadow_next_stamp = '0;

  reply_t pending_replies [$];
  int     fail_count = 0;
  int     words_sent = 0;
  int     replies_checked = 0;
  int     inserts_refused = 0;
  int     fetches_refused = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  bit     no_idle = 1'b0;

  max_priority_queue_unit #(
    .CAPACITY(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .prio_level(prio_level),
    .record_id(record_id),
    .holder_age(holder_age),
    .done(done),
    .status(status),
    .out_prio(out_prio),
    .out_record(out_record),
    .out_age(out_age),
    .entry_count(entry_count),
    .is_empty(is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_valid[i] = 1'b0;
  end

  function automatic reply_t compute_reply(input logic [1:0] m, input logic [7:0] p,
                                           input logic [15:0] r, input logic [7:0] a);
    reply_t      res;
    int          slot;
    int          best;
    logic [7:0]  best_prio;
    logic [15:0] best_span;
    logic [15:0] span;
    res = '0;
    slot = -1;
    best = -1;
    best_prio = '0;
    best_span = '0;
    if (m == MODE_INSERT) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!shadow_valid[i] && slot < 0) slot = i;
      end
      if (slot < 0) begin
        res.status = STATUS_FULL;
        inserts_refused++;
      end else begin
        shadow_prio[slot] = p;
        shadow_record[slot] = r;
        shadow_age[slot] = a;
        shadow_stamp[slot] = shadow_next_stamp;
        shadow_valid[slot] = 1'b1;
        shadow_next_stamp = shadow_next_stamp + 16'd1;
        shadow_count++;
        res.status = STATUS_OK;
        res.prio = p;
        res.record = r;
        res.age = a;
      end
    end else begin
      // Older entries win ties; age is measured modulo the 16-bit stamp.
      for (int i = 0; i < DEPTH; i++) begin
        if (shadow_valid[i]) begin
          span = shadow_next_stamp - shadow_stamp[i];
          if (best < 0 || shadow_prio[i] > best_prio ||
              (shadow_prio[i] == best_prio && span > best_span)) begin
            best = i;
            best_prio = shadow_prio[i];
            best_span = span;
          end
        end
      end
      if (best < 0) begin
        res.status = STATUS_EMPTY;
        fetches_refused++;
      end else begin
        res.status = STATUS_OK;
        res.prio = shadow_prio[best];
        res.record = shadow_record[best];
        res.age = shadow_age[best];
        if (m == MODE_REMOVE) begin
          shadow_valid[best] = 1'b0;
          shadow_count--;
        end
      end
    end
    res.count = shadow_count[4:0];
    res.empty = (shadow_count == 0);
    return res;
  endfunction

  task automatic send_word(input logic [1:0] m, input logic [7:0] p,
                           input logic [15:0] r, input logic [7:0] a);
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!no_idle) begin
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 30);
      else gap = $urandom_range(0, 13);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    prio_level <= p;
    record_id <= r;
    holder_age <= a;
    do @(posedge clk); while (busy);
    pending_replies.push_back(compute_reply(m, p, r, a));
    words_sent++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic empty_the_queue();
    while (shadow_count > 0) send_word(MODE_REMOVE, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic test_empty_queue();
    send_word(MODE_REMOVE, 8'($urandom), 16'($urandom), 8'($urandom));
    send_word(MODE_PEEK, 8'($urandom), 16'($urandom), 8'($urandom));
    send_word(MODE_PEEK_ALT, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic test_field_extremes();
    send_word(MODE_INSERT, 8'h00, 16'h0000, 8'h00);
    send_word(MODE_INSERT, 8'hFF, 16'hFFFF, 8'hFF);
    send_word(MODE_PEEK, 8'h00, 16'h0000, 8'h00);
    send_word(MODE_PEEK_ALT, 8'hFF, 16'hFFFF, 8'hFF);
    send_word(MODE_REMOVE, 8'hFF, 16'hFFFF, 8'hFF);
    send_word(MODE_REMOVE, 8'h00, 16'h0000, 8'h00);
    send_word(MODE_REMOVE, 8'hFF, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_priority_ties();
    send_word(MODE_INSERT, 8'h40, 16'h1111, 8'h01);
    send_word(MODE_INSERT, 8'h40, 16'h2222, 8'h02);
    send_word(MODE_INSERT, 8'h40, 16'h3333, 8'h03);
    send_word(MODE_INSERT, 8'h41, 16'h4444, 8'h04);
    send_word(MODE_INSERT, 8'h40, 16'h5555, 8'h05);
    send_word(MODE_REMOVE, 8'($urandom), 16'($urandom), 8'($urandom));
    send_word(MODE_REMOVE, 8'($urandom), 16'($urandom), 8'($urandom));
    // The freed low slot now takes the newest entry, which must still lose its tie.
    send_word(MODE_INSERT, 8'h40, 16'h6666, 8'h06);
    repeat (5) send_word(MODE_REMOVE, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic test_full_queue();
    empty_the_queue();
    while (shadow_count < DEPTH) begin
      send_word(MODE_INSERT, 8'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
    end
    send_word(MODE_INSERT, 8'($urandom), 16'($urandom), 8'($urandom));
    send_word(MODE_INSERT, 8'($urandom), 16'($urandom), 8'($urandom));
    hold_until_drained();
    send_word(MODE_PEEK, 8'($urandom), 16'($urandom), 8'($urandom));
    empty_the_queue();
    send_word(MODE_REMOVE, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic test_random_traffic(input int n);
    bit         filling;
    int         pick;
    logic [1:0] m;
    logic [7:0] p;
    filling = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (shadow_count == DEPTH) filling = 1'b0;
      else if (shadow_count == 0) filling = 1'b1;
      else if ($urandom_range(0, 39) == 0) filling = !filling;
      pick = $urandom_range(0, 99);
      if (pick < 12) m = MODE_PEEK;
      else if (pick < 17) m = MODE_PEEK_ALT;
      else if (pick < (filling ? 77 : 37)) m = MODE_INSERT;
      else m = MODE_REMOVE;
      case ($urandom_range(0, 3))
        0, 1: p = 8'($urandom_range(0, 3));
        2: p = 8'($urandom);
        default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      send_word(m, p, 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 59) == 0) hold_until_drained();
    end
  endtask

  task automatic test_long_stay();
    no_idle = 1'b1;
    empty_the_queue();
    send_word(MODE_INSERT, 8'h10, 16'hA0A0, 8'h0A);
    // Higher-priority churn goes in and out while the first entry stays.
    for (int k = 0; k < CHURN_PAIRS; k++) begin
      send_word(MODE_INSERT, 8'hFF, 16'($urandom), 8'($urandom));
      send_word(MODE_REMOVE, 8'($urandom), 16'($urandom), 8'($urandom));
    end
    send_word(MODE_INSERT, 8'h10, 16'hB0B0, 8'h0B);
    send_word(MODE_PEEK, 8'($urandom), 16'($urandom), 8'($urandom));
    repeat (3) send_word(MODE_REMOVE, 8'($urandom), 16'($urandom), 8'($urandom));
    no_idle = 1'b0;
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : check_reply
    reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: result word with nothing expected, expected none, actual status %0h",
                   $time, status);
        end
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        note_mismatch("status", int'(want.status), int'(status));
        note_mismatch("out_prio", int'(want.prio), int'(out_prio));
        note_mismatch("out_record", int'(want.record), int'(out_record));
        note_mismatch("out_age", int'(want.age), int'(out_age));
        note_mismatch("entry_count", int'(want.count), int'(entry_count));
        note_mismatch("is_empty", int'(want.empty), int'(is_empty));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_field_extremes();
    test_priority_ties();
    test_full_queue();
    test_random_traffic(600);
    test_long_stay();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    fail_count += pending_replies.size();
    $display("Sent %0d command words (%0d inserts refused as full, %0d removes or peeks",
             words_sent, inserts_refused, fetches_refused);
    $display("refused as empty) and checked %0d result words, long-lived entries included.",
             replies_checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: max_priority_queue_unit.f
rtl/mpq_pkg.sv
rtl/max_priority_queue_unit.sv
sim/tb_max_priority_queue_unit.sv
